// ===== hw/rtl/bmvm_pkg.sv =====
package bmvm_pkg;

   // word and field widths
   localparam int WORD_BITS         = 64;
   localparam int INDEX_BITS        = 10;
   localparam int ROT_BITS          = 6;
   localparam int KIND_BITS         = 2;
   localparam int COUNT_BITS        = 11;
   localparam int DEFAULT_MAX_WORDS = 1024;

   // word count after reset
   localparam logic [COUNT_BITS-1:0] WORDS_RESET = 11'd1024;

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_APPLY = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic fetch;
      logic execute;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/bit_matrix_vector_multiply.sv =====
// Boolean matrix times bit vector over 64-bit words, the matrix fed as
// diagonal pieces. Kind 0 loads a vector word and clears the result word of
// the same index, kind 1 rotates a vector word left, masks it and ORs it into
// a result word, kind 2 returns a result word; every item gives one result,
// with status 1 when an index is not below the word count or the memory
// depth (or the kind is unused). Each item is captured on its input
// transfer, then both single-port word memories are read synchronously,
// then the merge is written back as its result is registered. The next item
// is taken in the cycle right after write-back, while the previous result
// may still wait in the output register; a result stalled longer holds the
// block in its write-back cycle.
// Both memories are undefined after reset and need no clearing pass; load a
// vector word before using it, which also clears its result word. The word
// count register is written through the csr port, which is always ready, and
// must only be written while no item is in flight.
module bit_matrix_vector_multiply #(
   parameter int MAX_WORDS = bmvm_pkg::DEFAULT_MAX_WORDS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bmvm_pkg::KIND_BITS-1:0]    req_kind,
   input  logic [bmvm_pkg::INDEX_BITS-1:0]   req_row_index,
   input  logic [bmvm_pkg::INDEX_BITS-1:0]   req_column_index,
   input  logic [bmvm_pkg::ROT_BITS-1:0]     req_rotate_amount,
   input  logic [bmvm_pkg::WORD_BITS-1:0]    req_diag_mask,
   input  logic [bmvm_pkg::WORD_BITS-1:0]    req_word_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic [bmvm_pkg::WORD_BITS-1:0]    rsp_read_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bmvm_pkg::COUNT_BITS-1:0]   csr_data
);
   import bmvm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of one item at a time
   bmvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, merge logic and output register
   bmvm_datapath #(
      .MAX_WORDS (MAX_WORDS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_column_index  (req_column_index),
      .req_rotate_amount (req_rotate_amount),
      .req_diag_mask     (req_diag_mask),
      .req_word_value    (req_word_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_word     (rsp_read_word),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

endmodule

// ===== hw/rtl/bmvm_ctrl.sv =====
module bmvm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bmvm_pkg::status_type status,
   output bmvm_pkg::cmd_type    cmd
);
   import bmvm_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/bmvm_datapath.sv =====
module bmvm_datapath #(
   parameter int MAX_WORDS = bmvm_pkg::DEFAULT_MAX_WORDS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bmvm_pkg::cmd_type                 cmd,
   output bmvm_pkg::status_type              status,
   input  logic [bmvm_pkg::KIND_BITS-1:0]    req_kind,
   input  logic [bmvm_pkg::INDEX_BITS-1:0]   req_row_index,
   input  logic [bmvm_pkg::INDEX_BITS-1:0]   req_column_index,
   input  logic [bmvm_pkg::ROT_BITS-1:0]     req_rotate_amount,
   input  logic [bmvm_pkg::WORD_BITS-1:0]    req_diag_mask,
   input  logic [bmvm_pkg::WORD_BITS-1:0]    req_word_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic [bmvm_pkg::WORD_BITS-1:0]    rsp_read_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bmvm_pkg::COUNT_BITS-1:0]   csr_data
);
   import bmvm_pkg::*;

   localparam int ADDR_BITS = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [WORD_BITS-1:0] vector_mem [MAX_WORDS];
   logic [WORD_BITS-1:0] result_mem [MAX_WORDS];

   logic [COUNT_BITS-1:0] words_in_use_ff;

   logic [KIND_BITS-1:0]  kind_ff;
   logic [ADDR_BITS-1:0]  row_addr_ff;
   logic [ADDR_BITS-1:0]  col_addr_ff;
   logic [ROT_BITS-1:0]   rot_ff;
   logic [WORD_BITS-1:0]  mask_ff;
   logic [WORD_BITS-1:0]  data_ff;
   logic                  row_ok_ff;
   logic                  col_ok_ff;
   logic                  row_ok_in;
   logic                  col_ok_in;

   logic [WORD_BITS-1:0]  vec_rd_ff;
   logic [WORD_BITS-1:0]  res_rd_ff;

   logic                  load_ok;
   logic                  apply_ok;
   logic                  read_ok;
   logic [2*WORD_BITS-1:0] rot_wide;
   logic [WORD_BITS-1:0]  res_wr_data;
   logic [ADDR_BITS-1:0]  res_wr_addr;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_status_ff;
   logic [WORD_BITS-1:0]  rsp_word_ff;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_in_use_ff <= WORDS_RESET;
      end else if (csr_valid) begin
         words_in_use_ff <= csr_data;
      end
   end

   // index range checks against word count and memory depth
   assign row_ok_in = ({1'b0, req_row_index} < words_in_use_ff) &&
                      (32'(req_row_index) < 32'(MAX_WORDS));
   assign col_ok_in = ({1'b0, req_column_index} < words_in_use_ff) &&
                      (32'(req_column_index) < 32'(MAX_WORDS));

   // capture the item on its input transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         row_addr_ff <= ADDR_BITS'(req_row_index);
         col_addr_ff <= ADDR_BITS'(req_column_index);
         rot_ff      <= req_rotate_amount;
         mask_ff     <= req_diag_mask;
         data_ff     <= req_word_value;
         row_ok_ff   <= row_ok_in;
         col_ok_ff   <= col_ok_in;
      end
   end

   // registered memory reads
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         vec_rd_ff <= vector_mem[col_addr_ff];
         res_rd_ff <= result_mem[row_addr_ff];
      end
   end

   // decode of the operation
   assign load_ok  = (kind_ff == KIND_LOAD) && col_ok_ff;
   assign apply_ok = (kind_ff == KIND_APPLY) && row_ok_ff && col_ok_ff;
   assign read_ok  = (kind_ff == KIND_READ) && row_ok_ff;

   // left rotate by taking the upper half of the doubled word
   assign rot_wide = {vec_rd_ff, vec_rd_ff} << rot_ff;

   // result write: load clears, apply merges the masked piece
   always_comb begin
      if (load_ok) begin
         res_wr_addr = col_addr_ff;
         res_wr_data = '0;
      end else begin
         res_wr_addr = row_addr_ff;
         res_wr_data = res_rd_ff | (rot_wide[2*WORD_BITS-1:WORD_BITS] & mask_ff);
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.execute && load_ok) begin
         vector_mem[col_addr_ff] <= data_ff;
      end
      if (cmd.execute && (load_ok || apply_ok)) begin
         result_mem[res_wr_addr] <= res_wr_data;
      end
   end

   // output register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_status_ff <= !(load_ok || apply_ok || read_ok);
         rsp_word_ff   <= read_ok ? res_rd_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_word = rsp_word_ff;

endmodule
